FILE: hdl/ocf_pkg.sv
package ocf_pkg;

    // field and register widths
    localparam int CoordW     = 11;
    localparam int DimW       = 12;
    localparam int LabelW     = 16;
    localparam int NumCorners = 4;
    localparam int CornerIdW  = 2;
    localparam int CfgAddrW   = 2;
    localparam int CfgDataW   = 16;
    localparam int InDataW    = 40;
    localparam int OutDataW   = 24;

    // largest map side; larger register values are clamped to it
    localparam logic [DimW-1:0] MaxDim = 12'd2048;

    // configuration register indexes
    localparam logic [CfgAddrW-1:0] CfgObjectLabel = 2'd0;
    localparam logic [CfgAddrW-1:0] CfgImageWidth  = 2'd1;
    localparam logic [CfgAddrW-1:0] CfgImageHeight = 2'd2;

    // corner ids
    localparam logic [CornerIdW-1:0] CornerTopLeft     = 2'd0;
    localparam logic [CornerIdW-1:0] CornerTopRight    = 2'd1;
    localparam logic [CornerIdW-1:0] CornerBottomLeft  = 2'd2;
    localparam logic [CornerIdW-1:0] CornerBottomRight = 2'd3;

    // one object pixel offered to a corner tracker
    typedef struct packed {
        logic              hit;
        logic [CoordW-1:0] distance;
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
    } t_cand;

    // best pixel kept for one corner
    typedef struct packed {
        logic              found;
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
    } t_corner;

    typedef t_corner [NumCorners-1:0] t_corner_set;

endpackage

FILE: hdl/ocf_corner_track.sv
module ocf_corner_track (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_clear,
    input  logic             i_right,
    input  ocf_pkg::t_cand   i_cand,
    output ocf_pkg::t_corner o_next
);

    logic                       r_have;
    logic [ocf_pkg::CoordW-1:0] r_dist;
    logic [ocf_pkg::CoordW-1:0] r_col;
    logic [ocf_pkg::CoordW-1:0] r_row;
    logic                       take;
    logic                       tie_win;

    // tie goes to the column closer to this corner's side
    assign tie_win = i_right ? (i_cand.col > r_col) : (i_cand.col < r_col);

    assign take = i_cand.hit &&
                  (!r_have || (i_cand.distance < r_dist) ||
                   ((i_cand.distance == r_dist) && tie_win));

    // best pixel including the current one
    always_comb begin
        o_next.found = r_have || take;
        o_next.col   = take ? i_cand.col : r_col;
        o_next.row   = take ? i_cand.row : r_row;
    end

    // tracker state, cleared after the frame's last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_dist <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_step) begin
            if (i_clear) begin
                r_have <= 1'b0;
                r_dist <= '0;
                r_col  <= '0;
                r_row  <= '0;
            end else if (take) begin
                r_have <= 1'b1;
                r_dist <= i_cand.distance;
                r_col  <= i_cand.col;
                r_row  <= i_cand.row;
            end
        end
    end

endmodule

FILE: hdl/ocf_result_buf.sv
module ocf_result_buf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  ocf_pkg::t_corner_set              i_corners,
    output logic                              o_busy,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ocf_pkg::OutDataW-1:0]      o_data,
    output logic                              o_found,
    output logic                              o_last
);

    logic                          r_busy;
    logic [ocf_pkg::CornerIdW-1:0] r_idx;
    ocf_pkg::t_corner_set          r_ent;
    ocf_pkg::t_corner              cur;

    assign cur     = r_ent[r_idx];
    assign o_busy  = r_busy;
    assign o_valid = r_busy;
    assign o_data  = {cur.found ? cur.row : {ocf_pkg::CoordW{1'b0}},
                      cur.found ? cur.col : {ocf_pkg::CoordW{1'b0}},
                      r_idx};
    assign o_found = cur.found;
    assign o_last  = (r_idx == ocf_pkg::CornerBottomRight);

    // snapshot of the four corners, sent out one transfer per corner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= ocf_pkg::CornerTopLeft;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= ocf_pkg::CornerTopLeft;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == ocf_pkg::CornerBottomRight) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_corners;
        end
    end

endmodule

FILE: hdl/object_corner_finder_unit.sv
// object corner finder
// s_axis carries a label map in raster order, one pixel per transfer:
// tdata = pixel_x, pixel_y, pixel_label; tlast marks the map's last pixel.
// For each quadrant the pixel with the configured label nearest that image
// corner (Manhattan distance) is tracked by one of four parallel trackers.
// After the last pixel, m_axis sends four transfers, top-left, top-right,
// bottom-left, bottom-right: tdata = corner id, x, y; tuser = found;
// tlast on the fourth. A missing corner reports zero coordinates.
// Throughput is one pixel per cycle while no last pixel waits for the corner
// buffer. A last pixel is registered in the input register and then loaded
// into the corner buffer, which offers the four corners one after another.
// The corner snapshot is a single buffer: a last pixel waits in the input
// register while the previous four corners are still being sent, up to and
// including the cycle of the final corner transfer; apart from reset, this is
// the only case where s_axis_tready drops, and m_axis back-pressure prolongs it.
// Reset (synchronous, active low) holds s_axis_tready low and clears
// trackers, output and the registers to label 0 and a 2048 by 2048 map.
// Configuration writes take effect at once and are meant to happen between maps.
module object_corner_finder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [ocf_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [ocf_pkg::CfgDataW-1:0]  i_cfg_wdata,
    // pixel stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ocf_pkg::InDataW-1:0]   s_axis_tdata,  // pixel_x, pixel_y, pixel_label, pad
    input  logic                          s_axis_tlast,
    // corner stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ocf_pkg::OutDataW-1:0]  m_axis_tdata,  // corner_id, corner_x, corner_y
    output logic                          m_axis_tuser,  // corner_found
    output logic                          m_axis_tlast
);

    logic [ocf_pkg::LabelW-1:0] r_obj_label;
    logic [ocf_pkg::DimW-1:0]   r_width;
    logic [ocf_pkg::DimW-1:0]   r_height;

    logic                       r_in_valid;
    logic                       r_in_end;
    logic [ocf_pkg::CoordW-1:0] r_x;
    logic [ocf_pkg::CoordW-1:0] r_y;
    logic [ocf_pkg::LabelW-1:0] r_label;

    logic [ocf_pkg::DimW-1:0]   w;
    logic [ocf_pkg::DimW-1:0]   h;
    logic [ocf_pkg::DimW-1:0]   hw;
    logic [ocf_pkg::DimW-1:0]   hh;
    logic [ocf_pkg::DimW-1:0]   x_ext;
    logic [ocf_pkg::DimW-1:0]   y_ext;
    logic [ocf_pkg::DimW-1:0]   mx;
    logic [ocf_pkg::DimW-1:0]   my;
    logic [ocf_pkg::CoordW-1:0] distance;
    logic                       in_obj;
    logic                       left;
    logic                       right;
    logic                       top;
    logic                       bottom;
    logic                       consume;
    logic                       buf_busy;
    logic [ocf_pkg::NumCorners-1:0] quad_hit;
    logic [ocf_pkg::NumCorners-1:0] quad_right;

    ocf_pkg::t_cand       cand [ocf_pkg::NumCorners];
    ocf_pkg::t_corner_set next_corners;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_label <= '0;
            r_width     <= ocf_pkg::MaxDim;
            r_height    <= ocf_pkg::MaxDim;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ocf_pkg::CfgObjectLabel: r_obj_label <= i_cfg_wdata;
                ocf_pkg::CfgImageWidth:  r_width     <= i_cfg_wdata[ocf_pkg::DimW-1:0];
                ocf_pkg::CfgImageHeight: r_height    <= i_cfg_wdata[ocf_pkg::DimW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register; a last pixel holds here while the corner buffer is busy
    assign consume       = r_in_valid && (!r_in_end || !buf_busy);
    assign s_axis_tready = i_rst_n && (!r_in_valid || consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_x      <= s_axis_tdata[10:0];
            r_y      <= s_axis_tdata[21:11];
            r_label  <= s_axis_tdata[37:22];
            r_in_end <= s_axis_tlast;
        end
    end

    // quadrant membership and mirrored distance
    assign w     = (r_width  > ocf_pkg::MaxDim) ? ocf_pkg::MaxDim : r_width;
    assign h     = (r_height > ocf_pkg::MaxDim) ? ocf_pkg::MaxDim : r_height;
    assign hw    = w >> 1;
    assign hh    = h >> 1;
    assign x_ext = {1'b0, r_x};
    assign y_ext = {1'b0, r_y};

    assign in_obj = (x_ext < w) && (y_ext < h) && (r_label == r_obj_label);
    assign left   = x_ext < hw;
    assign right  = x_ext >= (w - hw);
    assign top    = y_ext < hh;
    assign bottom = y_ext >= (h - hh);
    assign mx     = right  ? (w - 12'd1 - x_ext) : x_ext;
    assign my     = bottom ? (h - 12'd1 - y_ext) : y_ext;
    assign distance = mx[ocf_pkg::CoordW-1:0] + my[ocf_pkg::CoordW-1:0];

    assign quad_hit   = {in_obj && right && bottom, in_obj && left && bottom,
                         in_obj && right && top,    in_obj && left && top};
    assign quad_right = 4'b1010;

    // one tracker per corner
    for (genvar c = 0; c < ocf_pkg::NumCorners; c++) begin : g_corner
        always_comb begin
            cand[c].hit      = quad_hit[c];
            cand[c].distance = distance;
            cand[c].col      = r_x;
            cand[c].row      = r_y;
        end

        ocf_corner_track u_track (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (consume),
            .i_clear (r_in_end),
            .i_right (quad_right[c]),
            .i_cand  (cand[c]),
            .o_next  (next_corners[c])
        );
    end

    // corner results
    ocf_result_buf u_result (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (consume && r_in_end),
        .i_corners (next_corners),
        .o_busy    (buf_busy),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_found   (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    // the final corner transfer carries the bottom-right id
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == ocf_pkg::CornerBottomRight)
        else $error("last corner transfer without bottom-right id");

    // a corner without an object pixel reports zero coordinates
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:2] == '0)
        else $error("missing corner with nonzero coordinates");

    // a new snapshot never starts in the cycle after the final corner leaves
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("corner buffer reloaded without a gap");

    // a held last pixel blocks new input while corners are still going out
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_end && m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a last pixel waits for the buffer");

endmodule
